@@ rtl/core/lpra_pkg.sv @@
// ----------------------------------------------------------------------------
// lpra_pkg
// Shared types and constants of the large-page run allocator.
// ----------------------------------------------------------------------------
package lpra_pkg;

	// directory geometry
	localparam int DIR_ENTRIES = 512;
	localparam int FRAME_BITS  = 40;
	localparam int ADDR_W      = $clog2(DIR_ENTRIES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int ENTRY_W     = 1 + FRAME_BITS;

	// field widths
	localparam int REQ_W   = 2;
	localparam int LEN_W   = 10;
	localparam int START_W = 9;
	localparam int PHYS_W  = 52;
	localparam int STAT_W  = 2;
	localparam int VA_W    = 64;
	localparam int PFN_W   = PHYS_W - 12;

	// wide enough for start + length and for DIR_ENTRIES
	localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

	// 2 MiB large page
	localparam int LP_SHIFT = 21;
	localparam int LP_PFN_SHIFT = LP_SHIFT - 12;
	localparam logic [FRAME_BITS-1:0] FRAME_STEP = FRAME_BITS'(1) << LP_PFN_SHIFT;

	localparam logic [VA_W-1:0] HEAP_BASE_RESET = 64'hFFFF_FFFF_C000_0000;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC  = 2'd0,
		REQ_FREE   = 2'd1,
		REQ_MAP    = 2'd2,
		REQ_UNUSED = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_RUN   = 2'd1,
		ST_ZERO_LEN = 2'd2,
		ST_PAST_END = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_WRITE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

endpackage

@@ rtl/core/lpra_req_if.sv @@
// ----------------------------------------------------------------------------
// lpra_req_if
// Request channel: valid/ready with one request beat.
// ----------------------------------------------------------------------------
interface lpra_req_if;
	import lpra_pkg::*;

	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [LEN_W-1:0]   run_length;
	logic [START_W-1:0] start_index;
	logic [PHYS_W-1:0]  phys_address;

	modport source (output valid, req_type, run_length, start_index, phys_address,
		input ready);
	modport sink (input valid, req_type, run_length, start_index, phys_address,
		output ready);
endinterface

@@ rtl/core/lpra_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lpra_rsp_if
// Result channel: valid/ready with one result beat.
// ----------------------------------------------------------------------------
interface lpra_rsp_if;
	import lpra_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [START_W-1:0] run_start;
	logic [VA_W-1:0]    virtual_address;

	modport source (output valid, status, run_start, virtual_address, input ready);
	modport sink (input valid, status, run_start, virtual_address, output ready);
endinterface

@@ rtl/core/lpra_ram.sv @@
// ----------------------------------------------------------------------------
// lpra_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/core/large_page_run_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// large_page_run_allocator_unit
// First-fit allocator of contiguous runs in a large-page directory held in RAM.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            beat contents
//  -------  ---  -------------------  --------------------------------------
//  req      in   valid/ready          req_type, run_length, start_index,
//                                     phys_address
//  rsp      out  valid/ready          status, run_start, virtual_address
//  cfg      in   cfg_we (no stall)    cfg_wdata -> heap_base
//
//  Steps: allocate scans the directory, then writes the run it found;
//    free and map only write the run; flagged or unused requests go
//    straight to the result. The directory RAM port does one
//    entry per cycle: the scan reads one, the run update writes one.
//  Reset: a clearing pass writes every directory entry to zero while
//    req.ready stays low. cfg writes are taken as ever.
//  Stalls: one request in flight at a time. The finished result sits in a
//    pending register until the rsp output register is free; a new request
//    is taken while a result still waits on rsp.
//
module large_page_run_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	lpra_req_if.sink                      req,
	lpra_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [lpra_pkg::VA_W-1:0]     cfg_wdata
);
	import lpra_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DIR_ENTRIES - 1);

	state_t state_q;

	logic [VA_W-1:0] heap_base_q;

	// directory RAM port
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	// scan
	logic [ADDR_W-1:0] rd_ptr_q;
	logic              rd_more_q;
	logic              valid_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  run_begin_q;
	logic [LEN_W-1:0]  len_q;

	// run update
	logic [ADDR_W-1:0]     wr_ptr_q;
	logic [ADDR_W-1:0]     wr_last_q;
	logic                  wr_present_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic                  frame_step_q;

	// pending result
	status_t          pend_status_q;
	logic [CNT_W-1:0] pend_start_q;
	logic             pend_va_en_q;

	// output register
	logic               rsp_valid_q;
	status_t            rsp_status_q;
	logic [START_W-1:0] rsp_start_q;
	logic [VA_W-1:0]    rsp_va_q;

	logic              accept;
	logic              rsp_free;
	logic              entry_present;
	logic [CNT_W-1:0]  count_n;
	logic              found;
	logic              scan_end;
	logic [SUM_W-1:0]  end_sum;
	logic              past_end;
	logic [PFN_W-1:0]  map_pfn;

	lpra_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DIR_ENTRIES)
	) u_dir (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.run_start       = rsp_start_q;
	assign rsp.virtual_address = rsp_va_q;

	// memory port: writes come from the clearing pass or the run update
	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
	assign mem_waddr = wr_ptr_q;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : {wr_present_q, frame_q};
	assign mem_re    = (state_q == S_SCAN) && rd_more_q;
	assign mem_raddr = rd_ptr_q;

	// first-fit scan on the entry that came back from RAM this cycle
	assign entry_present = mem_rdata[ENTRY_W-1];
	assign count_n  = entry_present ? '0 : count_q + CNT_W'(1);
	assign found    = valid_s1 && !entry_present &&
		(SUM_W'(count_n) >= SUM_W'(len_q));
	assign scan_end = valid_s1 && !found && (idx_s1 == LAST_IDX);

	// free/map bounds
	assign end_sum  = SUM_W'(req.start_index) + SUM_W'(req.run_length);
	assign past_end = end_sum > SUM_W'(DIR_ENTRIES);

	// frame number of the 2 MiB-aligned map address
	assign map_pfn = {req.phys_address[PHYS_W-1:LP_SHIFT], LP_PFN_SHIFT'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= HEAP_BASE_RESET;
		end else if (cfg_we) begin
			heap_base_q <= cfg_wdata;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			wr_ptr_q    <= '0;
			rd_more_q   <= 1'b0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					wr_ptr_q <= wr_ptr_q + ADDR_W'(1);
					if (wr_ptr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						valid_s1  <= 1'b0;
						rd_more_q <= 1'b1;
						if (req.req_type == REQ_UNUSED || req.run_length == '0) begin
							state_q <= S_DONE;
						end else if (req.req_type == REQ_ALLOC) begin
							state_q <= S_SCAN;
						end else if (past_end) begin
							state_q <= S_DONE;
						end else begin
							wr_ptr_q <= ADDR_W'(req.start_index);
							state_q  <= S_WRITE;
						end
					end
				end
				S_SCAN: begin
					valid_s1 <= mem_re;
					// stop reading after the last entry or once the run is found
					if (found || (mem_re && rd_ptr_q == LAST_IDX)) begin
						rd_more_q <= 1'b0;
					end
					if (found) begin
						wr_ptr_q  <= ADDR_W'(run_begin_q);
						state_q   <= S_WRITE;
					end else if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_WRITE: begin
					wr_ptr_q <= wr_ptr_q + ADDR_W'(1);
					if (wr_ptr_q == wr_last_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase

			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					len_q        <= req.run_length;
					rd_ptr_q     <= '0;
					count_q      <= '0;
					run_begin_q  <= '0;
					pend_start_q <= '0;
					pend_va_en_q <= 1'b0;
					wr_last_q    <= ADDR_W'(end_sum - SUM_W'(1));
					wr_present_q <= (req.req_type == REQ_MAP);
					frame_step_q <= (req.req_type == REQ_MAP);
					frame_q      <= (req.req_type == REQ_MAP) ? FRAME_BITS'(map_pfn) : '0;
					if (req.req_type == REQ_UNUSED) begin
						pend_status_q <= ST_OK;
					end else if (req.run_length == '0) begin
						pend_status_q <= ST_ZERO_LEN;
					end else if (req.req_type != REQ_ALLOC && past_end) begin
						pend_status_q <= ST_PAST_END;
					end else begin
						pend_status_q <= ST_OK;
					end
				end
			end
			S_SCAN: begin
				if (mem_re) begin
					rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
				end
				idx_s1 <= rd_ptr_q;
				if (valid_s1) begin
					count_q <= count_n;
					if (entry_present) begin
						run_begin_q <= CNT_W'(idx_s1) + CNT_W'(1);
					end
				end
				if (found) begin
					wr_last_q     <= idx_s1;
					wr_present_q  <= 1'b1;
					frame_q       <= '0;
					frame_step_q  <= 1'b0;
					pend_status_q <= ST_OK;
					pend_start_q  <= run_begin_q;
					pend_va_en_q  <= 1'b1;
				end else if (scan_end) begin
					pend_status_q <= ST_NO_RUN;
				end
			end
			S_WRITE: begin
				if (frame_step_q) begin
					frame_q <= frame_q + FRAME_STEP;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					rsp_status_q <= pend_status_q;
					rsp_start_q  <= START_W'(pend_start_q);
					rsp_va_q     <= pend_va_en_q ?
						heap_base_q + (VA_W'(pend_start_q) << LP_SHIFT) : '0;
				end
			end
			default: begin
			end
		endcase
	end

	// the clearing pass only ever writes empty entries and holds off requests
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (mem_we && mem_wdata == '0 && !req.ready))
		else $error("clearing pass wrote data or took a request");

	// the run update never wraps past the directory end
	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |=> (state_q == S_DONE || wr_ptr_q != '0 ||
			$past(wr_ptr_q) != LAST_IDX))
		else $error("run update wrapped past the directory end");

	// a new result beat is loaded only out of the done state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !$past(rsp_valid_q)) |-> $past(state_q == S_DONE))
		else $error("result beat appeared without a finished request");

	// no RAM read while the run update writes
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re)
		else $error("directory read during write phase");

endmodule

@@ tb/sv/lpra_run_checker.sv @@
// ----------------------------------------------------------------------------
// lpra_run_checker
// Watches the request and result channels, predicts each result and compares.
// ----------------------------------------------------------------------------
module lpra_run_checker
	import lpra_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	lpra_req_if             req,
	lpra_rsp_if             rsp,
	input  logic            cfg_we,
	input  logic [VA_W-1:0] cfg_wdata,
	output int              beats_checked,
	output int              fail_count,
	output int              grants,
	output int              refusals,
	output int              flagged
);

	typedef struct packed {
		status_t            status;
		logic [START_W-1:0] run_start;
		logic [VA_W-1:0]    va;
	} run_result_t;

	// frames never reach an output, so only presence is tracked
	logic            in_use [DIR_ENTRIES];
	logic [VA_W-1:0] heap_base_q;
	run_result_t     awaited_q [$];

	function automatic run_result_t resolve_request(input req_t kind,
			input logic [LEN_W-1:0] len, input logic [START_W-1:0] first);
		run_result_t r;
		int          base;
		int          count;
		int          i;
		bit          found;
		r = '{status: ST_OK, run_start: '0, va: '0};
		base = 0;
		count = 0;
		found = 1'b0;
		if (kind == REQ_UNUSED)
			return r;
		if (len == '0) begin
			r.status = ST_ZERO_LEN;
			flagged++;
			return r;
		end
		if (kind == REQ_ALLOC) begin
			// first fit: lowest run of free entries
			for (i = 0; i < DIR_ENTRIES && !found; i++) begin
				if (in_use[i]) begin
					base = i + 1;
					count = 0;
				end else begin
					count++;
					if (count >= int'(len))
						found = 1'b1;
				end
			end
			if (!found) begin
				r.status = ST_NO_RUN;
				refusals++;
				return r;
			end
			for (i = base; i < base + int'(len); i++)
				in_use[i] = 1'b1;
			r.run_start = START_W'(base);
			r.va = heap_base_q + (VA_W'(base) << LP_SHIFT);
			grants++;
			return r;
		end
		if (int'(first) + int'(len) > DIR_ENTRIES) begin
			r.status = ST_PAST_END;
			flagged++;
			return r;
		end
		for (i = int'(first); i < int'(first) + int'(len); i++)
			in_use[i] = (kind == REQ_MAP);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		run_result_t want;
		int          errs;
		if (!arst_n) begin
			for (int i = 0; i < DIR_ENTRIES; i++)
				in_use[i] = 1'b0;
			heap_base_q = HEAP_BASE_RESET;
			awaited_q.delete();
			grants = 0;
			refusals = 0;
			flagged = 0;
			beats_checked <= 0;
			fail_count <= 0;
		end else begin
			errs = 0;
			if (cfg_we)
				heap_base_q = cfg_wdata;
			// result first: it can never belong to a request taken at this edge
			if (rsp.valid && rsp.ready) begin
				if (awaited_q.size() == 0) begin
					$error("result beat with no request waiting: status %0d", rsp.status);
					errs++;
				end else begin
					want = awaited_q.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errs++;
					end
					if (rsp.run_start !== want.run_start) begin
						$error("run_start: expected %0d, got %0d", want.run_start,
							rsp.run_start);
						errs++;
					end
					if (rsp.virtual_address !== want.va) begin
						$error("virtual_address: expected %h, got %h", want.va,
							rsp.virtual_address);
						errs++;
					end
				end
				beats_checked <= beats_checked + 1;
			end
			if (req.valid && req.ready)
				awaited_q.push_back(resolve_request(req_t'(req.req_type), req.run_length,
					req.start_index));
			if (errs > 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the large-page run allocator: a directed sweep of edge cases, then
// random allocate/free/map traffic over several heap base settings, with
// random gaps and stalls on both channels. A side checker scores results.
// ----------------------------------------------------------------------------
module testbench;
	import lpra_pkg::*;

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 140;
	localparam int GAP_MAX      = 8;
	// worst case per beat is a full scan plus a full run write, plus both
	// idle draws; 865 beats of that, taken several times over
	localparam int LIMIT_CYCLES = 4_000_000;
	// allocate latency bound, used once at the end
	localparam int DRAIN_CYCLES = 2 * DIR_ENTRIES + 8;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            cfg_we    = 1'b0;
	logic [VA_W-1:0] cfg_wdata = '0;

	lpra_req_if req_ch ();
	lpra_rsp_if rsp_ch ();

	int beats_checked;
	int fail_count;
	int grants;
	int refusals;
	int flagged;
	int items_sent  = 0;
	int cycle_count = 0;
	// set for phases that run back to back with no idling on either side
	bit steady      = 1'b0;

	large_page_run_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lpra_run_checker u_run_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.beats_checked (beats_checked),
		.fail_count    (fail_count),
		.grants        (grants),
		.refusals      (refusals),
		.flagged       (flagged)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("[large_page_run_allocator_unit] ERROR");
			$finish;
		end
	end

	// One request beat. The gap is drawn per beat; valid stays high when the
	// next beat follows with no gap, so it is never dropped and raised in one
	// step. Returns at the edge where the beat was taken.
	task automatic send_beat(input req_t kind, input logic [LEN_W-1:0] len,
			input logic [START_W-1:0] first, input logic [PHYS_W-1:0] phys);
		int gap;
		gap = steady ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.req_type     <= kind;
		req_ch.run_length   <= len;
		req_ch.start_index  <= first;
		req_ch.phys_address <= phys;
		req_ch.valid        <= 1'b1;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		items_sent++;
	endtask

	// Hold off the sender until every result owed has come back.
	// beats_checked moves on the edge, so the value read here is settled.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (beats_checked != items_sent)
			@(posedge clk);
	endtask

	task automatic write_heap_base(input logic [VA_W-1:0] value);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly well-formed traffic: small allocations that fragment the
	// directory, frees and maps over live runs, now and then a full sweep
	// free so it does not stay full. About a tenth is noise: zero length,
	// the unused request type and runs past the end.
	task automatic random_beat();
		int                 pick;
		int                 size_pick;
		req_t               kind;
		logic [LEN_W-1:0]   len;
		logic [START_W-1:0] first;
		logic [PHYS_W-1:0]  phys;
		first = START_W'($urandom_range(0, DIR_ENTRIES - 1));
		phys  = PHYS_W'({$urandom, $urandom});
		pick  = $urandom_range(0, 99);
		if (pick < 45) begin
			kind = REQ_ALLOC;
			size_pick = $urandom_range(0, 99);
			if (size_pick < 70)
				len = LEN_W'($urandom_range(1, 8));
			else if (size_pick < 90)
				len = LEN_W'($urandom_range(9, 64));
			else if (size_pick < 97)
				len = LEN_W'($urandom_range(65, DIR_ENTRIES - 1));
			else
				len = LEN_W'($urandom_range(DIR_ENTRIES, 1023));
		end else if (pick < 50) begin
			kind  = REQ_FREE;
			first = '0;
			len   = LEN_W'(DIR_ENTRIES);
		end else if (pick < 72) begin
			kind = REQ_FREE;
			len  = LEN_W'($urandom_range(1, 32));
		end else if (pick < 90) begin
			kind = REQ_MAP;
			len  = LEN_W'($urandom_range(1, 32));
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					kind = req_t'($urandom_range(REQ_ALLOC, REQ_MAP));
					len  = '0;
				end
				1: begin
					kind = REQ_UNUSED;
					len  = LEN_W'($urandom_range(0, 1023));
				end
				default: begin
					kind = $urandom_range(0, 1) ? REQ_FREE : REQ_MAP;
					len  = LEN_W'($urandom_range(DIR_ENTRIES - int'(first) + 1, 1023));
				end
			endcase
		end
		send_beat(kind, len, first, phys);
	endtask

	// result side: stall drawn per beat, ready held until a beat is taken
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
		end
	end

	initial begin
		logic [VA_W-1:0] base;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = '0;
		req_ch.run_length   = '0;
		req_ch.start_index  = '0;
		req_ch.phys_address = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, heap base at its reset value.
		// zero length on every request type, unused type with and without length
		send_beat(REQ_ALLOC, '0, 9'd17, '0);
		send_beat(REQ_FREE, '0, 9'd3, '0);
		send_beat(REQ_MAP, '0, 9'd5, '1);
		send_beat(REQ_UNUSED, '0, '0, '0);
		send_beat(REQ_UNUSED, 10'd5, 9'h1AA, 52'hF_0F0F_0F0F_0F0F);
		// first fit from an empty directory
		send_beat(REQ_ALLOC, 10'd1, '0, '0);
		send_beat(REQ_ALLOC, 10'd3, '0, '0);
		// map the last entry from an unaligned all-ones address
		send_beat(REQ_MAP, 10'd1, 9'd511, '1);
		// one-entry hole at 1: a run of two skips it, a run of one takes it
		send_beat(REQ_FREE, 10'd1, 9'd1, '0);
		send_beat(REQ_ALLOC, 10'd2, '0, '0);
		send_beat(REQ_ALLOC, 10'd1, '0, '0);
		// runs past the end
		send_beat(REQ_FREE, 10'd2, 9'd511, '0);
		send_beat(REQ_MAP, 10'd13, 9'd500, 52'h0_0000_0020_0000);
		send_beat(REQ_FREE, 10'd1023, 9'd511, '0);
		// map over present entries, whole directory; then nothing fits
		send_beat(REQ_MAP, 10'd512, '0, '0);
		send_beat(REQ_ALLOC, 10'd1, '0, '0);
		// empty, the largest run, then lengths that can never fit
		send_beat(REQ_FREE, 10'd512, '0, '0);
		send_beat(REQ_ALLOC, 10'd512, '0, '0);
		send_beat(REQ_FREE, 10'd512, '0, '0);
		send_beat(REQ_ALLOC, 10'd513, '0, '0);
		send_beat(REQ_ALLOC, 10'd1023, '0, '0);
		// upper half mapped, lower half allocated, directory full again
		send_beat(REQ_MAP, 10'd256, 9'd256, 52'hA_5A5A_5A5F_FFFF);
		send_beat(REQ_ALLOC, 10'd256, '0, '0);
		send_beat(REQ_ALLOC, 10'd1, '0, '0);
		send_beat(REQ_FREE, 10'd512, '0, '0);

		// Random part: heap base rewritten between phases once the block is
		// idle; two phases run with no idling at all.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0:       base = '0;
				1:       base = '1;
				2:       base = 64'hFFFF_FFFF_FFE0_0000;
				default: base = {$urandom, $urandom};
			endcase
			write_heap_base(base);
			steady = (phase == 2) || (phase == 4);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 99) == 0)
					drain();
				random_beat();
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d requests: %0d runs granted, %0d refused for room, %0d flagged,",
			items_sent, grants, refusals, flagged);
		$display("over %0d heap base settings with random and gap-free handshakes on both sides.",
			PHASES + 1);
		if (fail_count == 0)
			$display("[large_page_run_allocator_unit] OK");
		else
			$display("[large_page_run_allocator_unit] ERROR");
		$finish;
	end

endmodule
